// File: rtl/ecal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ecal_pkg
// Shared types, constants and calendar tables for the epoch-to-calendar unit.
// ============================================================================
package ecal_pkg;

    localparam int unsigned SECS_LEAP_YEAR   = 31622400;
    localparam int unsigned SECS_COMMON_YEAR = 31536000;
    localparam int unsigned SECS_PER_DAY     = 86400;
    localparam int unsigned SECS_PER_HOUR    = 3600;
    localparam int unsigned SECS_PER_MINUTE  = 60;

    localparam int unsigned SEC_W    = 32;
    localparam int unsigned YEAR_W   = 8;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned BIT_W    = 3;
    localparam int unsigned MLEN_W   = 22;

    localparam int unsigned OUT_BITS = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W + SECOND_W;
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [YEAR_W-1:0]  YEAR_MAX       = 8'd136;
    // The only multiple of 4 in range that is not a leap year is 2100.
    localparam logic [YEAR_W-1:0]  YEAR_CENTURY   = 8'd100;
    localparam logic [MONTH_W-1:0] MONTH_FIRST    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST     = 4'd12;
    localparam logic [BIT_W-1:0]   DAY_TOP_BIT    = 3'd4;
    localparam logic [BIT_W-1:0]   HOUR_TOP_BIT   = 3'd4;
    localparam logic [BIT_W-1:0]   MINUTE_TOP_BIT = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MINUTE,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_YEAR,
        OP_MONTH,
        OP_DAY,
        OP_HOUR,
        OP_MINUTE,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BIT_W-1:0] bit_idx;
    } cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } status_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] yoff);
        is_leap = (yoff[1:0] == 2'b00) && (yoff != YEAR_CENTURY);
    endfunction

    // Length of a month in seconds.
    function automatic logic [MLEN_W-1:0] month_secs(input logic [MONTH_W-1:0] month,
                                                     input logic              leap);
        logic [MLEN_W-1:0] len;
        len = MLEN_W'(31 * SECS_PER_DAY);
        case (month)
            4'd2:    len = leap ? MLEN_W'(29 * SECS_PER_DAY) : MLEN_W'(28 * SECS_PER_DAY);
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = MLEN_W'(30 * SECS_PER_DAY);
            default: len = MLEN_W'(31 * SECS_PER_DAY);
        endcase
        month_secs = len;
    endfunction

endpackage
`default_nettype wire

// File: rtl/epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// epoch_seconds_to_calendar_unit
// Converts seconds since 2000-01-01 00:00:00 into year, month, day, hour,
// minute and second.
// ============================================================================
//
//  Channel  Direction  Payload
//  s_       in         epoch_seconds (32 bits)
//  m_       out        year_offset, month_number, day_of_month, hour_value,
//                      minute_value, second_value (34 bits in 40)
//
//  The time from an item's input transfer to its result grows with
//  year_offset and month_number, set by the year search, which
//  subtracts one year length per cycle, and the month search after it.
//  Day, hour and minute take 5, 5 and 6 restoring division steps.
//  Reset is synchronous and clears the sequencer and the output valid.
//  A result waits in the output register; the next item is taken meanwhile
//  and stalls only at its own hand-off until that register is free.
//
module epoch_seconds_to_calendar_unit import ecal_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [SEC_W-1:0] s_tdata,   // [31:0] epoch_seconds
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // [7:0] year_offset, [11:8] month_number,
                                             // [16:12] day_of_month, [21:17] hour_value,
                                             // [27:22] minute_value, [33:28] second_value
);

    cmd_t    cmd;
    status_t status;

    ecal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ecal_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata_sec (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/ecal_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ecal_ctrl
// Sequencer: steps the datapath through the year search, the month search
// and the three restoring divisions, then hands the result to the output.
// ============================================================================
module ecal_ctrl import ecal_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t           state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bit_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bit_reg      <= bit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and bit counter.
    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (!status.year_fit) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (!status.month_fit) begin
                    state_next = ST_DAY;
                    bit_next   = DAY_TOP_BIT;
                end
            end
            ST_DAY: begin
                if (bit_reg == '0) begin
                    state_next = ST_HOUR;
                    bit_next   = HOUR_TOP_BIT;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_HOUR: begin
                if (bit_reg == '0) begin
                    state_next = ST_MINUTE;
                    bit_next   = MINUTE_TOP_BIT;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_MINUTE: begin
                if (bit_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath and handshake outputs.
    always_comb begin
        cmd.op      = OP_NONE;
        cmd.bit_idx = bit_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_YEAR:   cmd.op = OP_YEAR;
            ST_MONTH:  cmd.op = OP_MONTH;
            ST_DAY:    cmd.op = OP_DAY;
            ST_HOUR:   cmd.op = OP_HOUR;
            ST_MINUTE: cmd.op = OP_MINUTE;
            ST_OUT: begin
                if (out_free) begin
                    cmd.op = OP_OUT;
                end
            end
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        if (cmd.op == OP_OUT) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // A new result never overwrites one that is still waiting.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded while occupied");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_YEAR))
        else $error("accepted transfer did not start the year search");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while an item is in progress");

endmodule
`default_nettype wire

// File: rtl/ecal_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ecal_dp
// Datapath: remainder register with one shared subtract-and-compare, year
// and month counters, quotient registers and the result register.
// ============================================================================
module ecal_dp import ecal_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [SEC_W-1:0] s_tdata_sec,
    input  wire cmd_t             cmd,
    output status_t               status,
    output logic [OUT_W-1:0]      m_tdata
);

    logic [SEC_W-1:0]    rem_reg, rem_next;
    logic [YEAR_W-1:0]   yoff_reg, yoff_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [DAY_W-1:0]    dayq_reg, dayq_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic [OUT_W-1:0]    out_reg, out_next;

    logic             leap;
    logic [SEC_W-1:0] trial;
    logic             fits;
    logic [DAY_W-1:0] day_out;

    assign leap = is_leap(yoff_reg);

    // One operand for the shared compare, picked by the current step.
    always_comb begin
        case (cmd.op)
            OP_YEAR:   trial = leap ? SEC_W'(SECS_LEAP_YEAR) : SEC_W'(SECS_COMMON_YEAR);
            OP_MONTH:  trial = SEC_W'(month_secs(month_reg, leap));
            OP_DAY:    trial = SEC_W'(SECS_PER_DAY) << cmd.bit_idx;
            OP_HOUR:   trial = SEC_W'(SECS_PER_HOUR) << cmd.bit_idx;
            OP_MINUTE: trial = SEC_W'(SECS_PER_MINUTE) << cmd.bit_idx;
            default:   trial = '0;
        endcase
    end

    assign fits             = rem_reg >= trial;
    assign status.year_fit  = fits && (yoff_reg != YEAR_MAX);
    assign status.month_fit = fits && (month_reg != MONTH_LAST);
    assign day_out          = dayq_reg + 1'b1;

    always_comb begin
        rem_next    = rem_reg;
        yoff_next   = yoff_reg;
        month_next  = month_reg;
        dayq_next   = dayq_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        out_next    = out_reg;
        case (cmd.op)
            OP_LOAD: begin
                rem_next    = s_tdata_sec;
                yoff_next   = '0;
                month_next  = MONTH_FIRST;
                dayq_next   = '0;
                hour_next   = '0;
                minute_next = '0;
            end
            OP_YEAR: begin
                if (status.year_fit) begin
                    rem_next  = rem_reg - trial;
                    yoff_next = yoff_reg + 1'b1;
                end
            end
            OP_MONTH: begin
                if (status.month_fit) begin
                    rem_next   = rem_reg - trial;
                    month_next = month_reg + 1'b1;
                end
            end
            OP_DAY: begin
                if (fits) begin
                    rem_next  = rem_reg - trial;
                    dayq_next = dayq_reg | (DAY_W'(1) << cmd.bit_idx);
                end
            end
            OP_HOUR: begin
                if (fits) begin
                    rem_next  = rem_reg - trial;
                    hour_next = hour_reg | (HOUR_W'(1) << cmd.bit_idx);
                end
            end
            OP_MINUTE: begin
                if (fits) begin
                    rem_next    = rem_reg - trial;
                    minute_next = minute_reg | (MINUTE_W'(1) << cmd.bit_idx);
                end
            end
            OP_OUT: begin
                // What is left of the remainder is the second of the minute.
                out_next = OUT_W'({rem_reg[SECOND_W-1:0], minute_reg, hour_reg,
                                   day_out, month_reg, yoff_reg});
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        yoff_reg   <= yoff_next;
        month_reg  <= month_next;
        dayq_reg   <= dayq_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        out_reg    <= out_next;
    end

    assign m_tdata = out_reg;

    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_MONTH) |-> (yoff_reg <= YEAR_MAX))
        else $error("year offset out of range");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DAY) |-> (month_reg >= MONTH_FIRST && month_reg <= MONTH_LAST))
        else $error("month out of range");

    a_rem_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (rem_reg < SEC_W'(SECS_PER_MINUTE)))
        else $error("remainder too large after the minute division");

endmodule
`default_nettype wire
